// ===== rtl/bpsb_pkg.sv =====
`timescale 1ns / 1ps

package bpsb_pkg;

   localparam int NUM_CHAN = 4;

   typedef logic [7:0]          chan_type;
   typedef logic [31:0]         pixel_type;
   typedef logic [15:0]         frac_type;
   typedef logic signed [8:0]   diff_type;
   typedef logic signed [25:0]  lerp_prod_type;
   typedef logic signed [17:0]  alpha_prod_type;
   typedef logic [15:0]         mult_prod_type;

   typedef enum logic [1:0] {
      MODE_OVERWRITE = 2'd0,
      MODE_ALPHA     = 2'd1,
      MODE_ADD_SAT   = 2'd2,
      MODE_MULTIPLY  = 2'd3
   } blend_mode_type;

   localparam chan_type CHAN_MAX = 8'hff;

   // Channel positions within a pixel word
   localparam int CHAN_RED   = 0;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 2;
   localparam int CHAN_ALPHA = 3;

   function automatic chan_type chan_of(pixel_type p, int k);
      return p[8*k +: 8];
   endfunction

   function automatic diff_type chan_diff(chan_type b, chan_type a);
      return $signed({1'b0, b}) - $signed({1'b0, a});
   endfunction

   function automatic lerp_prod_type lerp_mul(diff_type d, frac_type f);
      lerp_prod_type df;
      lerp_prod_type ff;
      df = lerp_prod_type'(d);
      ff = lerp_prod_type'($signed({1'b0, f}));
      return df * ff;
   endfunction

   // Low byte of floor(prod / 65536) + a
   function automatic chan_type lerp_finish(lerp_prod_type prod, chan_type a);
      return prod[23:16] + a;
   endfunction

endpackage

// ===== rtl/bilinear_pixel_sample_blend.sv =====
`timescale 1ns / 1ps

// Bilinear pixel sample and blend.
// Input channel req_*: four neighbouring RGBA source pixels, the 0.16 x and y
// fractions and the current destination pixel, one transaction per pixel.
// Output channel rsp_*: the new destination pixel. Both channels use
// valid/ready; a transaction moves when valid and ready are both high.
// csr_wr_en/csr_wr_data write the blend mode (overwrite, alpha blend,
// saturating add, multiply); write it only while the block is empty.
// Each transaction passes through four register stages, in order: horizontal
// products, vertical products, blend products and the output register.
// Throughput is one pixel per cycle; each stage holds its own valid bit and
// advances whenever the stage after it is empty or moving, so bubbles close
// up while the receiver stalls and req_ready drops only once all four stages
// are full. No transaction is lost or repeated during a stall.
// Synchronous reset empties the pipeline and returns the mode to overwrite.
module bilinear_pixel_sample_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pixel_00,
   input  logic [31:0] req_pixel_01,
   input  logic [31:0] req_pixel_10,
   input  logic [31:0] req_pixel_11,
   input  logic [15:0] req_frac_x,
   input  logic [15:0] req_frac_y,
   input  logic [31:0] req_dest_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_pixel,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   localparam int NC = bpsb_pkg::NUM_CHAN;

   bpsb_pkg::blend_mode_type mode_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   // Stage 1: horizontal products
   bpsb_pkg::lerp_prod_type htop_in [NC];
   bpsb_pkg::lerp_prod_type hbot_in [NC];
   bpsb_pkg::lerp_prod_type htop_ff [NC];
   bpsb_pkg::lerp_prod_type hbot_ff [NC];
   bpsb_pkg::chan_type      atop_ff [NC];
   bpsb_pkg::chan_type      abot_ff [NC];
   bpsb_pkg::frac_type      fy1_ff;
   bpsb_pkg::pixel_type     dest1_ff;

   // Stage 2: vertical products
   bpsb_pkg::chan_type      t1_in   [NC];
   bpsb_pkg::chan_type      t2_in   [NC];
   bpsb_pkg::lerp_prod_type vprod_in [NC];
   bpsb_pkg::lerp_prod_type vprod_ff [NC];
   bpsb_pkg::chan_type      t1_ff   [NC];
   bpsb_pkg::pixel_type     dest2_ff;

   // Stage 3: blend products
   bpsb_pkg::chan_type       filt_in  [NC];
   bpsb_pkg::chan_type       col_in   [NC];
   bpsb_pkg::chan_type       dch_in   [NC];
   bpsb_pkg::alpha_prod_type aprod_in [NC];
   bpsb_pkg::mult_prod_type  mprod_in [NC];
   bpsb_pkg::chan_type       s3_ff    [NC];
   bpsb_pkg::chan_type       d3_ff    [NC];
   bpsb_pkg::alpha_prod_type aprod_ff [NC];
   bpsb_pkg::mult_prod_type  mprod_ff [NC];

   // Stage 4: output register
   bpsb_pkg::pixel_type out_in;
   bpsb_pkg::pixel_type out_ff;

   // Each stage moves when the next one is empty or moving
   assign adv4 = !v4_ff || rsp_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_ready     = adv1;
   assign rsp_valid     = v4_ff;
   assign rsp_out_pixel = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bpsb_pkg::MODE_OVERWRITE;
      end else if (csr_wr_en) begin
         mode_ff <= bpsb_pkg::blend_mode_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         htop_in[k] = bpsb_pkg::lerp_mul(
            bpsb_pkg::chan_diff(bpsb_pkg::chan_of(req_pixel_01, k),
                                bpsb_pkg::chan_of(req_pixel_00, k)), req_frac_x);
         hbot_in[k] = bpsb_pkg::lerp_mul(
            bpsb_pkg::chan_diff(bpsb_pkg::chan_of(req_pixel_11, k),
                                bpsb_pkg::chan_of(req_pixel_10, k)), req_frac_x);
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int k = 0; k < NC; k++) begin
            htop_ff[k] <= htop_in[k];
            hbot_ff[k] <= hbot_in[k];
            atop_ff[k] <= bpsb_pkg::chan_of(req_pixel_00, k);
            abot_ff[k] <= bpsb_pkg::chan_of(req_pixel_10, k);
         end
         fy1_ff   <= req_frac_y;
         dest1_ff <= req_dest_pixel;
      end
   end

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         t1_in[k]    = bpsb_pkg::lerp_finish(htop_ff[k], atop_ff[k]);
         t2_in[k]    = bpsb_pkg::lerp_finish(hbot_ff[k], abot_ff[k]);
         vprod_in[k] = bpsb_pkg::lerp_mul(bpsb_pkg::chan_diff(t2_in[k], t1_in[k]), fy1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         for (int k = 0; k < NC; k++) begin
            vprod_ff[k] <= vprod_in[k];
            t1_ff[k]    <= t1_in[k];
         end
         dest2_ff <= dest1_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         filt_in[k] = bpsb_pkg::lerp_finish(vprod_ff[k], t1_ff[k]);
      end
      // Swap red and blue in the sample
      col_in[bpsb_pkg::CHAN_RED]   = filt_in[bpsb_pkg::CHAN_BLUE];
      col_in[bpsb_pkg::CHAN_GREEN] = filt_in[bpsb_pkg::CHAN_GREEN];
      col_in[bpsb_pkg::CHAN_BLUE]  = filt_in[bpsb_pkg::CHAN_RED];
      col_in[bpsb_pkg::CHAN_ALPHA] = filt_in[bpsb_pkg::CHAN_ALPHA];
      for (int k = 0; k < NC; k++) begin
         dch_in[k]   = bpsb_pkg::chan_of(dest2_ff, k);
         aprod_in[k] = bpsb_pkg::alpha_prod_type'($signed({1'b0, col_in[bpsb_pkg::CHAN_ALPHA]}))
                     * bpsb_pkg::alpha_prod_type'(bpsb_pkg::chan_diff(col_in[k], dch_in[k]));
         mprod_in[k] = bpsb_pkg::mult_prod_type'(dch_in[k]) * bpsb_pkg::mult_prod_type'(col_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         for (int k = 0; k < NC; k++) begin
            s3_ff[k]    <= col_in[k];
            d3_ff[k]    <= dch_in[k];
            aprod_ff[k] <= aprod_in[k];
            mprod_ff[k] <= mprod_in[k];
         end
      end
   end

   always_comb begin
      logic [8:0] sum;
      sum    = '0;
      out_in = '0;
      for (int k = 0; k < NC; k++) begin
         sum = {1'b0, d3_ff[k]} + {1'b0, s3_ff[k]};
         unique case (mode_ff)
            bpsb_pkg::MODE_OVERWRITE: out_in[8*k +: 8] = s3_ff[k];
            bpsb_pkg::MODE_ALPHA:     out_in[8*k +: 8] = aprod_ff[k][15:8] + d3_ff[k];
            bpsb_pkg::MODE_ADD_SAT:   out_in[8*k +: 8] = sum[8] ? bpsb_pkg::CHAN_MAX : sum[7:0];
            bpsb_pkg::MODE_MULTIPLY:  out_in[8*k +: 8] = mprod_ff[k][15:8];
            default:                  out_in[8*k +: 8] = s3_ff[k];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         out_ff <= out_in;
      end
   end

   a_stall_holds_stage1: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !adv2 |=> v1_ff)
      else $error("stage 1 transaction dropped during stall");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready)
      else $error("input stalled with room in the pipeline");

   a_rsp_from_stage3: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v3_ff))
      else $error("result appeared without a stage 3 transaction");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("stalled result changed");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int IDLE_LIMIT   = 4000;
   localparam int PHASE_ITEMS  = 190;
   localparam int DRAIN_CYCLES = 10;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   bpsb_pkg::pixel_type   req_pixel_00   = '0;
   bpsb_pkg::pixel_type   req_pixel_01   = '0;
   bpsb_pkg::pixel_type   req_pixel_10   = '0;
   bpsb_pkg::pixel_type   req_pixel_11   = '0;
   bpsb_pkg::frac_type    req_frac_x     = '0;
   bpsb_pkg::frac_type    req_frac_y     = '0;
   bpsb_pkg::pixel_type   req_dest_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   bpsb_pkg::pixel_type   rsp_out_pixel;
   logic                  csr_wr_en      = 1'b0;
   logic [1:0]            csr_wr_data    = '0;

   bpsb_pkg::blend_mode_type cur_mode  = bpsb_pkg::MODE_OVERWRITE;
   bpsb_pkg::pixel_type      pending_pixels[$];
   bpsb_pkg::pixel_type      want_pixel;
   int unsigned              errors    = 0;
   int unsigned              idle_cycles = 0;
   int unsigned              rsp_hold  = 0;
   bit                       no_idle   = 1'b0;

   bilinear_pixel_sample_blend DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_00   (req_pixel_00),
      .req_pixel_01   (req_pixel_01),
      .req_pixel_10   (req_pixel_10),
      .req_pixel_11   (req_pixel_11),
      .req_frac_x     (req_frac_x),
      .req_frac_y     (req_frac_y),
      .req_dest_pixel (req_dest_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // a + floor((b - a) * f / 65536), low byte
   function automatic bpsb_pkg::chan_type lerp_chan(bpsb_pkg::chan_type a,
                                                    bpsb_pkg::chan_type b,
                                                    bpsb_pkg::frac_type f);
      int prod;
      prod = (int'(b) - int'(a)) * int'(f);
      return bpsb_pkg::chan_type'((prod >>> 16) + int'(a));
   endfunction

   function automatic bpsb_pkg::pixel_type blend_pixel(
         bpsb_pkg::pixel_type p00, bpsb_pkg::pixel_type p01,
         bpsb_pkg::pixel_type p10, bpsb_pkg::pixel_type p11,
         bpsb_pkg::frac_type fx, bpsb_pkg::frac_type fy,
         bpsb_pkg::pixel_type dst, bpsb_pkg::blend_mode_type mode);
      bpsb_pkg::chan_type  filt [bpsb_pkg::NUM_CHAN];
      bpsb_pkg::chan_type  smp [bpsb_pkg::NUM_CHAN];
      bpsb_pkg::chan_type  d;
      bpsb_pkg::chan_type  s;
      int                  r;
      bpsb_pkg::pixel_type o;
      for (int k = 0; k < bpsb_pkg::NUM_CHAN; k++) begin
         filt[k] = lerp_chan(lerp_chan(p00[8*k +: 8], p01[8*k +: 8], fx),
                             lerp_chan(p10[8*k +: 8], p11[8*k +: 8], fx), fy);
      end
      smp[bpsb_pkg::CHAN_RED]   = filt[bpsb_pkg::CHAN_BLUE];
      smp[bpsb_pkg::CHAN_GREEN] = filt[bpsb_pkg::CHAN_GREEN];
      smp[bpsb_pkg::CHAN_BLUE]  = filt[bpsb_pkg::CHAN_RED];
      smp[bpsb_pkg::CHAN_ALPHA] = filt[bpsb_pkg::CHAN_ALPHA];
      for (int k = 0; k < bpsb_pkg::NUM_CHAN; k++) begin
         d = dst[8*k +: 8];
         s = smp[k];
         case (mode)
            bpsb_pkg::MODE_OVERWRITE: r = int'(s);
            bpsb_pkg::MODE_ALPHA: begin
               r = ((int'(smp[bpsb_pkg::CHAN_ALPHA]) * (int'(s) - int'(d))) >>> 8)
                   + int'(d);
            end
            bpsb_pkg::MODE_ADD_SAT: begin
               r = int'(d) + int'(s);
               if (r > int'(bpsb_pkg::CHAN_MAX)) r = int'(bpsb_pkg::CHAN_MAX);
            end
            default: r = (int'(d) * int'(s)) >> 8;
         endcase
         o[8*k +: 8] = r[7:0];
      end
      return o;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic bpsb_pkg::pixel_type rand_pixel();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic bpsb_pkg::frac_type rand_frac();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: random stalls unless idling is switched off
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         rsp_hold  <= gap_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("out_pixel: unexpected transaction, expected none, actual %h",
                   rsp_out_pixel);
            errors++;
         end else begin
            want_pixel = pending_pixels.pop_front();
            if (rsp_out_pixel !== want_pixel) begin
               $error("out_pixel: expected %h, actual %h", want_pixel, rsp_out_pixel);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Valid stays high between back-to-back transactions
   task automatic send_pixel(bpsb_pkg::pixel_type p00, bpsb_pkg::pixel_type p01,
                             bpsb_pkg::pixel_type p10, bpsb_pkg::pixel_type p11,
                             bpsb_pkg::frac_type fx, bpsb_pkg::frac_type fy,
                             bpsb_pkg::pixel_type dst);
      int unsigned gap;
      gap = (!no_idle && $urandom_range(0, 2) == 0) ? gap_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_00   <= p00;
      req_pixel_01   <= p01;
      req_pixel_10   <= p10;
      req_pixel_11   <= p11;
      req_frac_x     <= fx;
      req_frac_y     <= fy;
      req_dest_pixel <= dst;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(blend_pixel(p00, p01, p10, p11, fx, fy, dst, cur_mode));
   endtask

   // Hold the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_blend_mode(bpsb_pkg::blend_mode_type mode);
      drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_mode     = mode;
   endtask

   // Runs before any register write, so the reset mode is overwrite
   task automatic test_filter_extremes();
      send_pixel('0, '0, '0, '0, '0, '0, '0);
      send_pixel('1, '1, '1, '1, '1, '1, '1);
      send_pixel(32'h1122_3344, 32'h5566_7788, 32'h99aa_bbcc, 32'hddee_ff00,
                 16'h0000, 16'h0000, 32'h0);
      send_pixel(32'h1122_3344, 32'h5566_7788, 32'h99aa_bbcc, 32'hddee_ff00,
                 16'hffff, 16'h0000, 32'h0);
      send_pixel(32'h1122_3344, 32'h5566_7788, 32'h99aa_bbcc, 32'hddee_ff00,
                 16'h0000, 16'hffff, 32'h0);
      send_pixel(32'h1122_3344, 32'h5566_7788, 32'h99aa_bbcc, 32'hddee_ff00,
                 16'hffff, 16'hffff, 32'h0);
      // negative differences exercise the flooring shift
      send_pixel(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0001, 16'hffff, 32'hffff_ffff);
      send_pixel(32'h00ff_00ff, 32'hff00_ff00, 32'h0f0f_f0f0, 32'hf0f0_0f0f,
                 16'h8000, 16'h7fff, 32'ha5a5_5a5a);
   endtask

   task automatic test_blend_modes();
      bpsb_pkg::blend_mode_type mode;
      mode = mode.first();
      do begin
         write_blend_mode(mode);
         send_pixel(32'h00c0_4020, 32'h00c0_4020, 32'h00c0_4020,
                    32'h00c0_4020, 16'h1234, 16'h4321, 32'h55aa_33cc);
         send_pixel(32'hff10_2030, 32'hff10_2030, 32'hff10_2030, 32'hff10_2030,
                    16'hffff, 16'h0000, 32'h80f0_e0d0);
         send_pixel(32'hf0c0_80ff, 32'hf0c0_80ff, 32'hf0c0_80ff, 32'hf0c0_80ff,
                    16'h8000, 16'h8000, 32'h4080_c0ff);
         send_pixel('1, '1, '1, '1, 16'h8000, 16'hffff, '1);
         mode = mode.next();
      end while (mode != mode.first());
   endtask

   task automatic random_items(int unsigned count);
      bpsb_pkg::pixel_type p00, p01, p10, p11, dst;
      bpsb_pkg::frac_type  fx, fy;
      for (int unsigned i = 0; i < count; i++) begin
         p00 = rand_pixel();
         p01 = rand_pixel();
         p10 = rand_pixel();
         p11 = rand_pixel();
         dst = rand_pixel();
         fx  = rand_frac();
         fy  = rand_frac();
         case ($urandom_range(0, 9))
            0: begin
               p01 = p00;
               p10 = p00;
               p11 = p00;
            end
            1: begin
               // smooth neighbourhood
               p01 = p00 ^ (32'($urandom) & 32'h0707_0707);
               p10 = p00 ^ (32'($urandom) & 32'h0707_0707);
               p11 = p00 ^ (32'($urandom) & 32'h0707_0707);
            end
            default: ;
         endcase
         send_pixel(p00, p01, p10, p11, fx, fy, dst);
         if ($urandom_range(0, 299) == 0) drain();
      end
   endtask

   task automatic test_random_modes();
      bpsb_pkg::blend_mode_type phase_modes[8];
      phase_modes = '{bpsb_pkg::MODE_ALPHA, bpsb_pkg::MODE_MULTIPLY,
                      bpsb_pkg::MODE_OVERWRITE, bpsb_pkg::MODE_ADD_SAT,
                      bpsb_pkg::MODE_ALPHA, bpsb_pkg::MODE_OVERWRITE,
                      bpsb_pkg::MODE_MULTIPLY, bpsb_pkg::MODE_ADD_SAT};
      foreach (phase_modes[i]) begin
         write_blend_mode(phase_modes[i]);
         no_idle = (i == 4);
         random_items(PHASE_ITEMS);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_filter_extremes();
      test_blend_modes();
      test_random_modes();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
